[rtl/qbat_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qbat_pkg: shared types and constants of the quadratic bezier arc tessellator
// payload structs, configuration register indexes and fixed arithmetic widths
// ----------------------------------------------------------------------------
package qbat_pkg;

    localparam int COORD_W    = 32;   // coordinate width, signed, 8 fraction bits
    localparam int CFG_IDX_W  = 3;    // configuration register index width
    localparam int CFG_DATA_W = 31;   // widest configuration register
    localparam int GAIN_W     = 16;
    localparam int ARC_W      = 31;
    localparam int SEG_W      = 7;
    localparam int DELTA_W    = COORD_W + 2;     // end minus start, signed
    localparam int C2_W       = COORD_W + 3;     // doubled control point, signed
    localparam int ROOT_W     = 34;              // distance bits
    localparam int RAD_W      = 2 * ROOT_W;      // sum of squares
    localparam int REM_W      = ROOT_W + 3;      // root remainder
    localparam int MUL_W      = 35;              // shared multiplier operand width

    localparam longint COORD_MAX = (64'sd1 <<< (COORD_W - 1)) - 64'sd1;
    localparam longint COORD_MIN = -COORD_MAX - 64'sd1;

    localparam logic [CFG_IDX_W-1:0] CFG_ARC_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARC_MIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ARC_MAX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENTS = 3'd3;

    localparam logic [GAIN_W-1:0] ARC_GAIN_RST = 16'd6554;
    localparam logic [ARC_W-1:0]  ARC_MIN_RST  = 31'd0;
    localparam logic [ARC_W-1:0]  ARC_MAX_RST  = 31'h7FFF_FFFF;
    localparam logic [SEG_W-1:0]  SEGMENTS_RST = 7'd16;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_z;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] end_z;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] from_x;
        logic signed [COORD_W-1:0] from_y;
        logic signed [COORD_W-1:0] from_z;
        logic signed [COORD_W-1:0] to_x;
        logic signed [COORD_W-1:0] to_y;
        logic signed [COORD_W-1:0] to_z;
        logic        [SEG_W-1:0]   segment_index;
        logic                      last;
    } t_out_item;

endpackage
`default_nettype wire

[rtl/quadratic_bezier_arc_tessellator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_bezier_arc_tessellator
// cuts a raised quadratic arc between two 3d points into line segments
// ----------------------------------------------------------------------------
// One transfer in gives a start and an end point; the block lifts the control
// point in z by the clamped, gain-scaled distance and emits N segments along
// the arc, the last one flagged. All math runs on one shared multiplier, a
// bit-serial square root and a bit-serial divider under a small sequencer, one
// item at a time; the root takes 34 steps once per item and the divider takes
// 2*W+35 steps once per axis and segment, W being clog2(MAX_SEGMENTS+1).
// The input side is ready only while idle; configuration writes are taken any
// time but should be made only while idle.
// ----------------------------------------------------------------------------
module quadratic_bezier_arc_tessellator #(
    parameter int MAX_SEGMENTS = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [qbat_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  wire logic [qbat_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire qbat_pkg::t_in_item                 i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output qbat_pkg::t_out_item                     o_out_data
);
    import qbat_pkg::*;

    localparam int N_W   = $clog2(MAX_SEGMENTS + 1);
    localparam int NN_W  = 2 * N_W;
    localparam int DIV_W = NN_W + 1;           // divisor is 2*N*N
    localparam int MAG_W = 2 * N_W + 35;       // magnitude of 2*num + N*N
    localparam int CNT_W = $clog2(MAG_W + 1);
    localparam logic signed [MAG_W:0] SAT_HI = (MAG_W + 1)'(COORD_MAX);
    localparam logic signed [MAG_W:0] SAT_LO = (MAG_W + 1)'(COORD_MIN);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_ROOT, S_GAIN, S_CLAMP, S_COEF,
        S_TERM, S_PREP, S_DIV, S_FIX, S_OUT
    } t_state;

    t_state                     r_state;
    logic                       r_out_valid;
    logic [GAIN_W-1:0]          r_gain;
    logic [ARC_W-1:0]           r_arc_min;
    logic [ARC_W-1:0]           r_arc_max;
    logic [SEG_W-1:0]           r_segments;

    // item registers
    logic signed [COORD_W-1:0]  r_s   [3];
    logic signed [COORD_W-1:0]  r_e   [3];
    logic signed [C2_W-1:0]     r_c2  [3];
    logic signed [DELTA_W-1:0]  r_d   [3];
    logic signed [COORD_W-1:0]  r_prev[3];
    logic signed [COORD_W-1:0]  r_cur [3];
    logic [N_W-1:0]             r_n;
    logic [N_W-1:0]             r_i;
    logic [1:0]                 r_ax;
    logic [CNT_W-1:0]           r_cnt;

    // shared multiplier
    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic signed [2*MUL_W-1:0]  r_prod;

    // distance and height
    logic [RAD_W-1:0]           r_sum;
    logic [RAD_W-1:0]           r_rad;
    logic [REM_W-1:0]           r_rem;
    logic [ROOT_W-1:0]          r_root;

    // curve point
    logic [NN_W-1:0]            r_aa, r_ab, r_bb;
    logic [DIV_W-1:0]           r_div;
    logic signed [MAG_W-1:0]    r_num;
    logic [MAG_W-1:0]           r_dq;
    logic [DIV_W-1:0]           r_drem;
    logic                       r_neg;

    logic [1:0]                 k_idx;
    logic [N_W-1:0]             coef_a;
    int                         seg_int;
    int                         n_clamp;
    logic [REM_W-1:0]           rt_rem;
    logic [REM_W-1:0]           rt_trial;
    logic                       rt_ge;
    logic [ROOT_W-1:0]          h_full;
    logic [ARC_W-1:0]           h_clamp;
    logic signed [MAG_W:0]      dv_x;
    logic [DIV_W:0]             dv_rem;
    logic                       dv_ge;
    logic signed [MAG_W:0]      fx_q;
    logic signed [COORD_W-1:0]  fx_sat;

    assign k_idx  = (r_cnt < CNT_W'(3)) ? r_cnt[1:0] : 2'd0;
    assign coef_a = r_n - r_i;

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SQ: begin
                mul_a = MUL_W'(r_d[k_idx]);
                mul_b = MUL_W'(r_d[k_idx]);
            end
            S_GAIN: begin
                mul_a = $signed({1'b0, r_root});
                mul_b = MUL_W'($signed({1'b0, r_gain}));
            end
            S_COEF: begin
                unique case (k_idx)
                    2'd1: begin
                        mul_a = MUL_W'($signed({1'b0, coef_a}));
                        mul_b = MUL_W'($signed({1'b0, r_i}));
                    end
                    2'd2: begin
                        mul_a = MUL_W'($signed({1'b0, r_i}));
                        mul_b = MUL_W'($signed({1'b0, r_i}));
                    end
                    default: begin
                        mul_a = MUL_W'($signed({1'b0, coef_a}));
                        mul_b = MUL_W'($signed({1'b0, coef_a}));
                    end
                endcase
                // fourth issue: n * n
                if (r_cnt == CNT_W'(3)) begin
                    mul_a = MUL_W'($signed({1'b0, r_n}));
                    mul_b = MUL_W'($signed({1'b0, r_n}));
                end
            end
            S_TERM: begin
                unique case (k_idx)
                    2'd1: begin
                        mul_a = MUL_W'($signed({1'b0, r_ab}));
                        mul_b = MUL_W'(r_c2[r_ax]);
                    end
                    2'd2: begin
                        mul_a = MUL_W'($signed({1'b0, r_bb}));
                        mul_b = MUL_W'(r_e[r_ax]);
                    end
                    default: begin
                        mul_a = MUL_W'($signed({1'b0, r_aa}));
                        mul_b = MUL_W'(r_s[r_ax]);
                    end
                endcase
            end
            default: ;
        endcase
    end

    // segment count clamp
    always_comb begin
        seg_int = int'(r_segments);
        if (seg_int < 2) begin
            n_clamp = 2;
        end else if (seg_int > MAX_SEGMENTS) begin
            n_clamp = MAX_SEGMENTS;
        end else begin
            n_clamp = seg_int;
        end
    end

    // square root step: two radicand bits per cycle
    always_comb begin
        rt_rem   = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        rt_trial = REM_W'({r_root, 2'b01});
        rt_ge    = (rt_rem >= rt_trial);
    end

    // arc height, floor of distance times gain / 2^16, then clamped
    always_comb begin
        h_full = r_prod[ROOT_W+GAIN_W-1:GAIN_W];
        if (h_full < ROOT_W'(r_arc_min)) begin
            h_clamp = r_arc_min;
        end else if (h_full < ROOT_W'(r_arc_max)) begin
            h_clamp = h_full[ARC_W-1:0];
        end else begin
            h_clamp = r_arc_max;
        end
    end

    // divider step and round to nearest, ties up
    always_comb begin
        dv_x   = ((MAG_W + 1)'(r_num) <<< 1)
               + (MAG_W + 1)'($signed({1'b0, r_div[DIV_W-1:1]}));
        dv_rem = {r_drem, r_dq[MAG_W-1]};
        dv_ge  = (dv_rem >= {1'b0, r_div});
        fx_q   = $signed({1'b0, r_dq});
        if (r_neg) begin
            fx_q = (r_drem != '0) ? (-fx_q - (MAG_W + 1)'(1)) : -fx_q;
        end
        if (fx_q > SAT_HI) begin
            fx_sat = COORD_W'(SAT_HI);
        end else if (fx_q < SAT_LO) begin
            fx_sat = COORD_W'(SAT_LO);
        end else begin
            fx_sat = COORD_W'(fx_q);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_gain      <= ARC_GAIN_RST;
            r_arc_min   <= ARC_MIN_RST;
            r_arc_max   <= ARC_MAX_RST;
            r_segments  <= SEGMENTS_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_ARC_GAIN: r_gain     <= i_cfg_wdata[GAIN_W-1:0];
                    CFG_ARC_MIN:  r_arc_min  <= i_cfg_wdata[ARC_W-1:0];
                    CFG_ARC_MAX:  r_arc_max  <= i_cfg_wdata[ARC_W-1:0];
                    CFG_SEGMENTS: r_segments <= i_cfg_wdata[SEG_W-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_s[0]  <= i_in_data.start_x;
                        r_s[1]  <= i_in_data.start_y;
                        r_s[2]  <= i_in_data.start_z;
                        r_e[0]  <= i_in_data.end_x;
                        r_e[1]  <= i_in_data.end_y;
                        r_e[2]  <= i_in_data.end_z;
                        r_prev[0] <= i_in_data.start_x;
                        r_prev[1] <= i_in_data.start_y;
                        r_prev[2] <= i_in_data.start_z;
                        r_d[0]  <= DELTA_W'(i_in_data.end_x) - DELTA_W'(i_in_data.start_x);
                        r_d[1]  <= DELTA_W'(i_in_data.end_y) - DELTA_W'(i_in_data.start_y);
                        r_d[2]  <= DELTA_W'(i_in_data.end_z) - DELTA_W'(i_in_data.start_z);
                        r_c2[0] <= C2_W'(i_in_data.start_x) + C2_W'(i_in_data.end_x);
                        r_c2[1] <= C2_W'(i_in_data.start_y) + C2_W'(i_in_data.end_y);
                        r_c2[2] <= C2_W'(i_in_data.start_z) + C2_W'(i_in_data.end_z);
                        r_n     <= N_W'(n_clamp);
                        r_sum   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    // each square is registered and arrives in the cycle after its issue
                    if (r_cnt != '0) begin
                        r_sum <= r_sum + r_prod[RAD_W-1:0];
                    end
                    if (r_cnt == CNT_W'(3)) begin
                        r_rad   <= r_sum + r_prod[RAD_W-1:0];
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_ROOT;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_ROOT: begin
                    r_rad  <= r_rad << 2;
                    r_rem  <= rt_ge ? (rt_rem - rt_trial) : rt_rem;
                    r_root <= {r_root[ROOT_W-2:0], rt_ge};
                    if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                        r_state <= S_GAIN;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_GAIN: begin
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    r_c2[2] <= r_c2[2] + $signed({3'b000, h_clamp, 1'b0});
                    r_i     <= N_W'(1);
                    r_cnt   <= '0;
                    r_state <= S_COEF;
                end
                S_COEF: begin
                    unique case (r_cnt)
                        CNT_W'(1): r_aa <= r_prod[NN_W-1:0];
                        CNT_W'(2): r_ab <= r_prod[NN_W-1:0];
                        CNT_W'(3): r_bb <= r_prod[NN_W-1:0];
                        CNT_W'(4): r_div <= {r_prod[NN_W-1:0], 1'b0};
                        default: ;
                    endcase
                    if (r_cnt == CNT_W'(4)) begin
                        r_cnt   <= '0;
                        r_ax    <= '0;
                        r_num   <= '0;
                        r_state <= S_TERM;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_TERM: begin
                    if (r_cnt != '0) begin
                        r_num <= r_num + MAG_W'(r_prod);
                    end
                    if (r_cnt == CNT_W'(3)) begin
                        r_state <= S_PREP;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_PREP: begin
                    r_neg   <= dv_x[MAG_W];
                    r_dq    <= MAG_W'(dv_x[MAG_W] ? -dv_x : dv_x);
                    r_drem  <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_drem <= DIV_W'(dv_ge ? (dv_rem - {1'b0, r_div}) : dv_rem);
                    r_dq   <= {r_dq[MAG_W-2:0], dv_ge};
                    if (r_cnt == CNT_W'(MAG_W - 1)) begin
                        r_state <= S_FIX;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_FIX: begin
                    r_cur[r_ax] <= fx_sat;
                    if (r_ax == 2'd2) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end else begin
                        r_ax    <= r_ax + 2'd1;
                        r_num   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_TERM;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        r_prev[0]   <= r_cur[0];
                        r_prev[1]   <= r_cur[1];
                        r_prev[2]   <= r_cur[2];
                        r_cnt       <= '0;
                        if (r_i == r_n) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + N_W'(1);
                            r_state <= S_COEF;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_out_data.from_x        = r_prev[0];
        o_out_data.from_y        = r_prev[1];
        o_out_data.from_z        = r_prev[2];
        o_out_data.to_x          = r_cur[0];
        o_out_data.to_y          = r_cur[1];
        o_out_data.to_z          = r_cur[2];
        o_out_data.segment_index = SEG_W'(r_i);
        o_out_data.last          = (r_i == r_n);
    end

    // result only ever shown from the output state
    a_valid_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_state == S_OUT))
        else $error("output valid outside output state");

    // input never taken while a segment is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("input ready while output pending");

    // divisor is set before any divide
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_div != '0))
        else $error("zero divisor");

    // the last segment ends the item
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_data.last) |=> (r_state == S_IDLE))
        else $error("no return to idle after last segment");

endmodule
`default_nettype wire
